// ----- hdl/voronoi_nearest_seed_pixel_core_macros.svh -----
// Assertion macros shared by the Voronoi seed rasterizer RTL.
`ifndef VORONOI_NEAREST_SEED_PIXEL_CORE_MACROS_SVH
`define VORONOI_NEAREST_SEED_PIXEL_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define VNS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define VNS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define VNS_ASSERT(lbl, clk, rstn, prop, msg)

`define VNS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- hdl/vns_pkg.sv -----
// Shared types and constants for the Voronoi nearest-seed rasterizer.
package vns_pkg;

    // Fixed field widths of the ports
    localparam int POS_W     = 10;
    localparam int SLOT_W    = 6;
    localparam int CHAN_W    = 8;
    localparam int COLOR_W   = 3 * CHAN_W;
    localparam int CNT_W     = 7;
    localparam int CFG_IDX_W = 2;

    // Default values of the top level parameters
    localparam int DEF_MAX_SEEDS   = 64;
    localparam int DEF_COORD_BITS  = 10;
    localparam int DEF_DISK_RADIUS = 5;

    // Distance metric codes
    localparam logic [1:0] METRIC_EUCLID    = 2'd0;
    localparam logic [1:0] METRIC_MANHATTAN = 2'd1;
    localparam logic [1:0] METRIC_CHEBYSHEV = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_METRIC     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_SPOTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_COUNT = 2'd2;

    // Input item modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Control flags of one beat travelling down the cell chain
    typedef struct packed {
        logic valid;
        logic query;
        logic found;
        logic spot;
    } t_ctl;

    // Configuration seen by every cell
    typedef struct packed {
        logic [1:0]       metric;
        logic             show_spots;
        logic [CNT_W-1:0] seed_count;
    } t_cfg;

endpackage

// ----- hdl/vns_cell.sv -----
// One seed cell: holds a seed and updates the running nearest-seed search.
module vns_cell import vns_pkg::*; #(
    parameter int INDEX       = 0,
    parameter int COORD_BITS  = DEF_COORD_BITS,
    parameter int DISK_RADIUS = DEF_DISK_RADIUS,
    parameter int DIST_W      = 2 * DEF_COORD_BITS + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  t_cfg                  i_cfg,
    input  t_ctl                  i_ctl,
    input  logic [COORD_BITS-1:0] i_x,
    input  logic [COORD_BITS-1:0] i_y,
    input  logic [SLOT_W-1:0]     i_slot,
    input  logic [COLOR_W-1:0]    i_color,
    input  logic [DIST_W-1:0]     i_dist,
    output t_ctl                  o_ctl,
    output logic [COORD_BITS-1:0] o_x,
    output logic [COORD_BITS-1:0] o_y,
    output logic [SLOT_W-1:0]     o_slot,
    output logic [COLOR_W-1:0]    o_color,
    output logic [DIST_W-1:0]     o_dist
);

    localparam logic [DIST_W-1:0] R2      = DIST_W'(DISK_RADIUS * DISK_RADIUS);
    localparam bit                SLOT_OK = (INDEX < (1 << SLOT_W));
    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

    // Stored seed
    logic [COORD_BITS-1:0] r_seed_x;
    logic [COORD_BITS-1:0] r_seed_y;
    logic [COLOR_W-1:0]    r_seed_c;

    // First stage registers
    t_ctl                  r1_ctl;
    logic [COORD_BITS-1:0] r1_x;
    logic [COORD_BITS-1:0] r1_y;
    logic [SLOT_W-1:0]     r1_slot;
    logic [COLOR_W-1:0]    r1_color;
    logic [DIST_W-1:0]     r1_dist;
    logic [COORD_BITS-1:0] r1_dx;
    logic [COORD_BITS-1:0] r1_dy;
    logic [DIST_W-1:0]     r1_dx2;
    logic [DIST_W-1:0]     r1_dy2;

    // Second stage registers
    t_ctl                  r2_ctl;
    logic [COORD_BITS-1:0] r2_x;
    logic [COORD_BITS-1:0] r2_y;
    logic [SLOT_W-1:0]     r2_slot;
    logic [COLOR_W-1:0]    r2_color;
    logic [DIST_W-1:0]     r2_dist;

    logic                  w_load;
    logic [COORD_BITS-1:0] w_dx;
    logic [COORD_BITS-1:0] w_dy;
    logic [DIST_W-1:0]     w_dx_ext;
    logic [DIST_W-1:0]     w_dy_ext;
    logic [DIST_W-1:0]     w_sum;
    logic [DIST_W-1:0]     w_manh;
    logic [DIST_W-1:0]     w_cheb;
    logic [DIST_W-1:0]     w_d;
    logic                  w_active;
    logic                  w_hit;
    logic                  w_take;
    logic                  w_spot;
    t_ctl                  n_ctl;
    logic [SLOT_W-1:0]     n_slot;
    logic [COLOR_W-1:0]    n_color;
    logic [DIST_W-1:0]     n_dist;

    // Catch a load beat addressed to this cell
    assign w_load = i_adv && i_ctl.valid && !i_ctl.query && SLOT_OK && (i_slot == MY_SLOT);

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_seed_x <= i_x;
            r_seed_y <= i_y;
            r_seed_c <= i_color;
        end
    end

    // Absolute offsets to the stored seed
    always_comb begin
        w_dx     = (i_x > r_seed_x) ? (i_x - r_seed_x) : (r_seed_x - i_x);
        w_dy     = (i_y > r_seed_y) ? (i_y - r_seed_y) : (r_seed_y - i_y);
        w_dx_ext = DIST_W'(w_dx);
        w_dy_ext = DIST_W'(w_dy);
    end

    // Advance the first stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else if (i_adv) begin
            r1_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_x     <= i_x;
            r1_y     <= i_y;
            r1_slot  <= i_slot;
            r1_color <= i_color;
            r1_dist  <= i_dist;
            r1_dx    <= w_dx;
            r1_dy    <= w_dy;
            r1_dx2   <= w_dx_ext * w_dx_ext;
            r1_dy2   <= w_dy_ext * w_dy_ext;
        end
    end

    // Select the metric distance
    always_comb begin
        w_sum  = r1_dx2 + r1_dy2;
        w_manh = DIST_W'(r1_dx) + DIST_W'(r1_dy);
        w_cheb = (r1_dx > r1_dy) ? DIST_W'(r1_dx) : DIST_W'(r1_dy);
        case (i_cfg.metric)
            METRIC_EUCLID:    w_d = w_sum;
            METRIC_MANHATTAN: w_d = w_manh;
            default:          w_d = w_cheb;
        endcase
    end

    // Compare against the running best; earlier seed keeps a tie
    always_comb begin
        w_active = int'(i_cfg.seed_count) > INDEX;
        w_hit    = r1_ctl.valid && r1_ctl.query && w_active;
        w_take   = w_hit && (!r1_ctl.found || (w_d < r1_dist));
        w_spot   = w_hit && i_cfg.show_spots && (w_sum <= R2);

        n_ctl       = r1_ctl;
        n_ctl.found = r1_ctl.found | w_hit;
        n_ctl.spot  = r1_ctl.spot | w_spot;
        n_slot      = w_take ? MY_SLOT  : r1_slot;
        n_color     = w_take ? r_seed_c : r1_color;
        n_dist      = w_take ? w_d      : r1_dist;
    end

    // Advance the second stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else if (i_adv) begin
            r2_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_x     <= r1_x;
            r2_y     <= r1_y;
            r2_slot  <= n_slot;
            r2_color <= n_color;
            r2_dist  <= n_dist;
        end
    end

    assign o_ctl   = r2_ctl;
    assign o_x     = r2_x;
    assign o_y     = r2_y;
    assign o_slot  = r2_slot;
    assign o_color = r2_color;
    assign o_dist  = r2_dist;

endmodule

// ----- hdl/voronoi_nearest_seed_pixel_core.sv -----
// Top level of the Voronoi nearest-seed pixel rasterizer.
// A chain of MAX_SEEDS cells, each holding one seed, carries every item down
// the row; each cell has two register stages (offsets and squares, then the
// compare). The block takes one item per clock while the result register is
// free or being drained. A query result passes both stages of every cell,
// then the output register; a load updates its cell as it passes and yields
// no result. Items stay in order, so a query sees exactly the loads accepted
// before it. The whole chain stalls while a finished result waits at the output.
`include "voronoi_nearest_seed_pixel_core_macros.svh"

module voronoi_nearest_seed_pixel_core import vns_pkg::*; #(
    parameter int MAX_SEEDS   = DEF_MAX_SEEDS,
    parameter int COORD_BITS  = DEF_COORD_BITS,
    parameter int DISK_RADIUS = DEF_DISK_RADIUS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data,
    // Input item channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_mode,
    input  logic [SLOT_W-1:0]    i_seed_slot,
    input  logic [POS_W-1:0]     i_pos_x,
    input  logic [POS_W-1:0]     i_pos_y,
    input  logic [CHAN_W-1:0]    i_load_red,
    input  logic [CHAN_W-1:0]    i_load_green,
    input  logic [CHAN_W-1:0]    i_load_blue,
    // Result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CHAN_W-1:0]    o_out_red,
    output logic [CHAN_W-1:0]    o_out_green,
    output logic [CHAN_W-1:0]    o_out_blue,
    output logic [SLOT_W-1:0]    o_nearest_slot,
    output logic                 o_seed_found,
    output logic                 o_on_spot
);

    localparam int DIST_W = ((2 * COORD_BITS + 1) > 11) ? (2 * COORD_BITS + 1) : 11;

    // Configuration registers
    logic [1:0]       r_metric;
    logic             r_show_spots;
    logic [CNT_W-1:0] r_seed_count;
    t_cfg             w_cfg;

    // Chain taps between cells
    t_ctl                  w_ctl   [MAX_SEEDS+1];
    logic [COORD_BITS-1:0] w_x     [MAX_SEEDS+1];
    logic [COORD_BITS-1:0] w_y     [MAX_SEEDS+1];
    logic [SLOT_W-1:0]     w_slot  [MAX_SEEDS+1];
    logic [COLOR_W-1:0]    w_color [MAX_SEEDS+1];
    logic [DIST_W-1:0]     w_dist  [MAX_SEEDS+1];

    logic                  w_adv;
    logic                  w_emit;
    logic                  w_paint;

    // Output register
    logic                  r_out_valid;
    logic [COLOR_W-1:0]    r_out_color;
    logic [SLOT_W-1:0]     r_out_slot;
    logic                  r_out_found;
    logic                  r_out_spot;

    // Take configuration beats at once
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric     <= METRIC_EUCLID;
            r_show_spots <= 1'b0;
            r_seed_count <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_METRIC:     r_metric     <= i_cfg_data[1:0];
                CFG_SHOW_SPOTS: r_show_spots <= i_cfg_data[0];
                CFG_SEED_COUNT: r_seed_count <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    assign w_cfg = '{metric: r_metric, show_spots: r_show_spots, seed_count: r_seed_count};

    // Advance the chain whenever the output register can take a result
    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    // Feed the head of the chain
    always_comb begin
        w_ctl[0]   = '{valid: i_in_valid, query: (i_mode == MODE_QUERY),
                       found: 1'b0, spot: 1'b0};
        w_x[0]     = COORD_BITS'(i_pos_x);
        w_y[0]     = COORD_BITS'(i_pos_y);
        w_slot[0]  = i_seed_slot;
        w_color[0] = {i_load_red, i_load_green, i_load_blue};
        w_dist[0]  = '0;
    end

    // Row of seed cells
    for (genvar g = 0; g < MAX_SEEDS; g++) begin : g_cell
        vns_cell #(
            .INDEX       (g),
            .COORD_BITS  (COORD_BITS),
            .DISK_RADIUS (DISK_RADIUS),
            .DIST_W      (DIST_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_cfg   (w_cfg),
            .i_ctl   (w_ctl[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_slot  (w_slot[g]),
            .i_color (w_color[g]),
            .i_dist  (w_dist[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_slot  (w_slot[g+1]),
            .o_color (w_color[g+1]),
            .o_dist  (w_dist[g+1])
        );
    end

    // Only query beats leave a result
    assign w_emit  = w_ctl[MAX_SEEDS].valid && w_ctl[MAX_SEEDS].query;
    assign w_paint = w_ctl[MAX_SEEDS].found && !w_ctl[MAX_SEEDS].spot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_emit;
        end
    end

    // Hold the finished result; black when nothing found or on a spot
    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out_color <= w_paint ? w_color[MAX_SEEDS] : '0;
            r_out_slot  <= w_ctl[MAX_SEEDS].found ? w_slot[MAX_SEEDS] : '0;
            r_out_found <= w_ctl[MAX_SEEDS].found;
            r_out_spot  <= w_ctl[MAX_SEEDS].spot;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_red      = r_out_color[3*CHAN_W-1:2*CHAN_W];
    assign o_out_green    = r_out_color[2*CHAN_W-1:CHAN_W];
    assign o_out_blue     = r_out_color[CHAN_W-1:0];
    assign o_nearest_slot = r_out_slot;
    assign o_seed_found   = r_out_found;
    assign o_on_spot      = r_out_spot;

    // A spot pixel is black and always has a winning seed
    `VNS_ASSERT(a_spot_black, i_clk, i_rst_n, (o_out_valid && o_on_spot) |-> (o_seed_found && o_out_red == '0 && o_out_green == '0 && o_out_blue == '0), "spot pixel not black")

    // No winner means black, slot zero and no spot
    `VNS_ASSERT(a_none_black, i_clk, i_rst_n, (o_out_valid && !o_seed_found) |-> (!o_on_spot && o_nearest_slot == '0 && o_out_red == '0 && o_out_green == '0 && o_out_blue == '0), "empty search not black")

    // An empty search range never finds a seed
    `VNS_ASSERT(a_count_zero, i_clk, i_rst_n, (o_out_valid && r_seed_count == '0) |-> !o_seed_found, "seed found with zero count")

    // Spots only appear while the overlay is on
    `VNS_ASSERT(a_spot_off, i_clk, i_rst_n, (o_out_valid && !r_show_spots) |-> !o_on_spot, "spot with overlay off")

    // Reset empties the output register
    `VNS_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

// ----- tb/sv/voronoi_nearest_seed_pixel_core_tb.sv -----
// Testbench for the Voronoi nearest-seed pixel core: directed and random beats, scoreboard check.
`timescale 1ns / 100ps

module voronoi_nearest_seed_pixel_core_tb;
    import vns_pkg::*;

    // Unused metric code, expected to behave as Chebyshev
    localparam logic [1:0] METRIC_ALIAS = 2'd3;
    // Register index that maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    // Chain latency plus margin, used before register writes and at the end
    localparam int DRAIN_CYCLES = 2 * DEF_MAX_SEEDS + 16;
    localparam int QUIET_LIMIT  = 5000;
    localparam int STALL_LEN    = 400;
    localparam int PHASE_ITEMS  = 190;
    localparam int NUM_PHASES   = 8;

    typedef struct packed {
        logic              mode;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_seed_beat;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [SLOT_W-1:0] slot;
        logic              found;
        logic              spot;
    } t_pixel;

    typedef struct packed {
        logic [1:0]       metric;
        logic             spots;
        logic [CNT_W-1:0] count;
    } t_phase_cfg;

    // Tracks the seed table and registers, predicts each queried pixel
    class pixel_scoreboard;
        logic [POS_W-1:0]   seed_x   [DEF_MAX_SEEDS];
        logic [POS_W-1:0]   seed_y   [DEF_MAX_SEEDS];
        logic [COLOR_W-1:0] seed_rgb [DEF_MAX_SEEDS];
        logic [1:0]         metric;
        logic               show_spots;
        logic [CNT_W-1:0]   seed_count;
        t_pixel             pending_pixels[$];
        int                 errors;

        function new();
            for (int i = 0; i < DEF_MAX_SEEDS; i++) begin
                seed_x[i]   = '0;
                seed_y[i]   = '0;
                seed_rgb[i] = '0;
            end
            metric     = METRIC_EUCLID;
            show_spots = 1'b0;
            seed_count = '0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
            case (idx)
                CFG_METRIC:     metric = data[1:0];
                CFG_SHOW_SPOTS: show_spots = data[0];
                CFG_SEED_COUNT: seed_count = data;
                default: ;
            endcase
        endfunction

        function int unsigned active_seeds();
            return (seed_count > DEF_MAX_SEEDS) ? DEF_MAX_SEEDS : seed_count;
        endfunction

        // Search the active seeds for the nearest one, apply the spot overlay
        function t_pixel nearest_pixel(logic [POS_W-1:0] px, logic [POS_W-1:0] py);
            int unsigned dx, dy, cand_dist, best_dist, best, lim;
            logic found, spot;
            logic [COLOR_W-1:0] rgb;
            t_pixel res;
            lim = active_seeds();
            found = 1'b0;
            spot = 1'b0;
            best = 0;
            best_dist = 0;
            rgb = '0;
            for (int i = 0; i < lim; i++) begin
                dx = (px > seed_x[i]) ? px - seed_x[i] : seed_x[i] - px;
                dy = (py > seed_y[i]) ? py - seed_y[i] : seed_y[i] - py;
                case (metric)
                    METRIC_EUCLID:    cand_dist = dx * dx + dy * dy;
                    METRIC_MANHATTAN: cand_dist = dx + dy;
                    default:          cand_dist = (dx > dy) ? dx : dy;
                endcase
                // strict compare: earlier seed keeps a tie
                if (!found || cand_dist < best_dist) begin
                    found = 1'b1;
                    best_dist = cand_dist;
                    best = i;
                end
                if (show_spots && dx * dx + dy * dy <= DEF_DISK_RADIUS * DEF_DISK_RADIUS)
                    spot = 1'b1;
            end
            if (found && !spot)
                rgb = seed_rgb[best];
            res.red   = rgb[23:16];
            res.green = rgb[15:8];
            res.blue  = rgb[7:0];
            res.slot  = found ? SLOT_W'(best) : '0;
            res.found = found;
            res.spot  = spot;
            return res;
        endfunction

        // Apply a load to the table, or queue the expected pixel of a query
        function void note_beat(t_seed_beat b);
            if (b.mode == MODE_LOAD) begin
                seed_x[b.slot]   = b.pos_x;
                seed_y[b.slot]   = b.pos_y;
                seed_rgb[b.slot] = {b.red, b.green, b.blue};
            end else begin
                pending_pixels.insert(pending_pixels.size(), nearest_pixel(b.pos_x, b.pos_y));
            end
        endfunction

        function void report(string field, int unsigned exp_v, int unsigned act_v);
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
        endfunction

        function void check_pixel(t_pixel got);
            t_pixel exp_p;
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                return;
            end
            exp_p = pending_pixels.pop_front();
            if (got.red   !== exp_p.red)   report("out_red", exp_p.red, got.red);
            if (got.green !== exp_p.green) report("out_green", exp_p.green, got.green);
            if (got.blue  !== exp_p.blue)  report("out_blue", exp_p.blue, got.blue);
            if (got.slot  !== exp_p.slot)  report("nearest_slot", exp_p.slot, got.slot);
            if (got.found !== exp_p.found) report("seed_found", exp_p.found, got.found);
            if (got.spot  !== exp_p.spot)  report("on_spot", exp_p.spot, got.spot);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CNT_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_mode = MODE_LOAD;
    logic [SLOT_W-1:0]    i_seed_slot = '0;
    logic [POS_W-1:0]     i_pos_x = '0;
    logic [POS_W-1:0]     i_pos_y = '0;
    logic [CHAN_W-1:0]    i_load_red = '0;
    logic [CHAN_W-1:0]    i_load_green = '0;
    logic [CHAN_W-1:0]    i_load_blue = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [CHAN_W-1:0]    o_out_red;
    logic [CHAN_W-1:0]    o_out_green;
    logic [CHAN_W-1:0]    o_out_blue;
    logic [SLOT_W-1:0]    o_nearest_slot;
    logic                 o_seed_found;
    logic                 o_on_spot;

    pixel_scoreboard sb = new();

    int send_idle_pct = 13;
    int recv_idle_pct = 60;
    int stall_cycles  = 0;
    int n_loads       = 0;
    int n_queries     = 0;
    int n_pixels      = 0;

    t_phase_cfg plan [NUM_PHASES] = '{
        '{METRIC_EUCLID,    1'b0, 7'd64},
        '{METRIC_MANHATTAN, 1'b1, 7'd64},
        '{METRIC_CHEBYSHEV, 1'b0, 7'd127},
        '{METRIC_ALIAS,     1'b1, 7'd33},
        '{METRIC_EUCLID,    1'b1, 7'd1},
        '{METRIC_MANHATTAN, 1'b0, 7'd0},
        '{METRIC_CHEBYSHEV, 1'b1, 7'd65},
        '{METRIC_EUCLID,    1'b0, 7'd64}
    };

    voronoi_nearest_seed_pixel_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_seed_slot    (i_seed_slot),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_load_red     (i_load_red),
        .i_load_green   (i_load_green),
        .i_load_blue    (i_load_blue),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_nearest_slot (o_nearest_slot),
        .o_seed_found   (o_seed_found),
        .o_on_spot      (o_on_spot)
    );

    always #6 i_clk = ~i_clk;

    // Check each accepted pixel beat, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_pixel({o_out_red, o_out_green, o_out_blue, o_nearest_slot,
                            o_seed_found, o_on_spot});
            n_pixels++;
        end
        if (stall_cycles > 0) begin
            stall_cycles--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // End the run when no channel moves a beat for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready) || !i_rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no beat for %0d cycles, %0d pixels still expected",
                 QUIET_LIMIT, sb.pending_pixels.size());
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_seed_beat load_beat(int slot, int x, int y, logic [COLOR_W-1:0] rgb);
        t_seed_beat b;
        b.mode  = MODE_LOAD;
        b.slot  = SLOT_W'(slot);
        b.pos_x = POS_W'(x);
        b.pos_y = POS_W'(y);
        {b.red, b.green, b.blue} = rgb;
        return b;
    endfunction

    function automatic t_seed_beat query_beat(int x, int y);
        t_seed_beat b;
        b.mode  = MODE_QUERY;
        b.slot  = SLOT_W'($urandom);
        b.pos_x = POS_W'(x);
        b.pos_y = POS_W'(y);
        b.red   = CHAN_W'($urandom);
        b.green = CHAN_W'($urandom);
        b.blue  = CHAN_W'($urandom);
        return b;
    endfunction

    // Mostly queries near active seeds, some wide or corner pixels, some reloads
    function automatic t_seed_beat random_beat();
        t_seed_beat b;
        int unsigned pick, lim, j;
        pick = $urandom_range(99);
        lim = sb.active_seeds();
        j = $urandom_range((lim == 0) ? DEF_MAX_SEEDS - 1 : lim - 1);
        if (pick < 15) begin
            b = load_beat($urandom_range(DEF_MAX_SEEDS - 1), $urandom, $urandom, COLOR_W'($urandom));
            // cluster half the reloads around an existing seed
            if ($urandom_range(1)) begin
                b.pos_x = sb.seed_x[j] + POS_W'($urandom_range(16)) - POS_W'(8);
                b.pos_y = sb.seed_y[j] + POS_W'($urandom_range(16)) - POS_W'(8);
            end
        end else if (pick < 60) begin
            b = query_beat(sb.seed_x[j] + $urandom_range(14) - 7,
                           sb.seed_y[j] + $urandom_range(14) - 7);
        end else if (pick < 72) begin
            b = query_beat($urandom_range(1) ? 1023 : 0, $urandom_range(1) ? 1023 : 0);
        end else begin
            b = query_beat($urandom, $urandom);
        end
        return b;
    endfunction

    // Offer one beat on the input channel; returns at the accepting edge
    task automatic send_beat(t_seed_beat b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= b.mode;
        i_seed_slot  <= b.slot;
        i_pos_x      <= b.pos_x;
        i_pos_y      <= b.pos_y;
        i_load_red   <= b.red;
        i_load_green <= b.green;
        i_load_blue  <= b.blue;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_beat(b);
        if (b.mode == MODE_LOAD)
            n_loads++;
        else
            n_queries++;
    endtask

    // Offer one register beat; valid stays high, the caller drops it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Drain the chain, then write all three registers
    task automatic reconfigure(t_phase_cfg c);
        i_in_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(CFG_METRIC, CNT_W'($urandom_range(31) << 2) | CNT_W'(c.metric));
        write_reg(CFG_SHOW_SPOTS, CNT_W'($urandom_range(63) << 1) | CNT_W'(c.spots));
        write_reg(CFG_SEED_COUNT, c.count);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        t_phase_cfg c;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // No seeds searched: black at both corners
        send_beat(query_beat(0, 0));
        send_beat(query_beat(1023, 1023));

        // Seeds at the corners, a tie pair and the top slot
        send_beat(load_beat(0, 0, 0, 24'hFF0000));
        send_beat(load_beat(1, 1023, 1023, 24'h00FF00));
        send_beat(load_beat(2, 100, 100, 24'h0000FF));
        send_beat(load_beat(3, 106, 100, 24'hA5C35A));
        send_beat(load_beat(63, 512, 512, 24'hFFFFFF));

        // Each metric, unused code included, on tie and metric-sensitive pixels
        for (int m = 0; m < 4; m++) begin
            c = '{m[1:0], 1'b0, 7'd4};
            reconfigure(c);
            send_beat(query_beat(103, 100));
            send_beat(query_beat(104, 105));
            send_beat(query_beat(105, 105));
        end

        // Spot overlay: on a seed, on the radius boundary, just outside
        c = '{METRIC_EUCLID, 1'b1, 7'd4};
        reconfigure(c);
        send_beat(query_beat(0, 0));
        send_beat(query_beat(103, 104));
        send_beat(query_beat(100, 106));

        // The unused register index must change nothing
        reconfigure(c);
        write_reg(CFG_UNUSED, CNT_W'($urandom));
        i_cfg_valid <= 1'b0;

        // Fill the remaining slots so every count searches loaded seeds
        for (int s = 4; s < DEF_MAX_SEEDS - 1; s++)
            send_beat(load_beat(s, $urandom, $urandom, COLOR_W'($urandom)));

        // Random phases across register settings and idle patterns
        for (int p = 0; p < NUM_PHASES; p++) begin
            reconfigure(plan[p]);
            if (p < 3) begin
                send_idle_pct = 13;
                recv_idle_pct = 60;
            end else if (p < 6) begin
                send_idle_pct = 60;
                recv_idle_pct = 13;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // hold off the result side long enough to back up the chain
            if (p == 1 || p == 6)
                stall_cycles = STALL_LEN;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_beat(random_beat());
        end

        // Drain and give stray results a chance to show up
        i_in_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d seed loads and %0d pixel queries (%0d pixels checked)",
                 n_loads, n_queries, n_pixels);
        $display("over all metrics, spot overlay on and off, seed counts 0 to 127");
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- voronoi_nearest_seed_pixel_core.f -----
+incdir+hdl
hdl/vns_pkg.sv
hdl/vns_cell.sv
hdl/voronoi_nearest_seed_pixel_core.sv
tb/sv/voronoi_nearest_seed_pixel_core_tb.sv
